// ===== sv/assert_macros.svh =====
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AFQ_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define AFQ_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: check failed");

`endif

// ===== sv/afq_pkg.sv =====
package afq_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUANT = 1'b1;

    localparam logic [1:0] CFG_CLAMP_LOW  = 2'd0;
    localparam logic [1:0] CFG_CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CFG_CHAN_MODE  = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [7:0]        channel;
        logic [31:0]       sample_bits;
        logic [31:0]       recip_scale_bits;
        logic signed [31:0] zero_offset;
    } afq_in_t;

    typedef struct packed {
        logic signed [31:0] qvalue;
        logic              nan_input;
    } afq_out_t;

    typedef struct packed {
        logic signed [31:0] clamp_low;
        logic signed [31:0] clamp_high;
        logic              per_channel_mode;
    } afq_cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] sample;
        logic [31:0] recip;
        logic [31:0] offset;
        logic        in_range;
    } afq_s1_t;

    typedef struct packed {
        logic              valid;
        logic              nan;
        logic              huge;
        logic              sign;
        logic signed [34:0] rint;
        logic signed [33:0] off;
    } afq_s5_t;

    // Position of the highest set bit, zero for zero.
    function automatic logic [5:0] lead_pos(input logic [37:0] x);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 38; i++) begin
            if (x[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // Round an integer magnitude to 24 significant bits, ties to even.
    function automatic logic [37:0] rne24(input logic [37:0] mag, input logic [5:0] lp);
        logic [5:0]  k;
        logic [37:0] q;
        logic [37:0] rem;
        logic [37:0] half;
        logic [37:0] res;
        logic        inc;
        k    = lp - 6'd23;
        q    = mag >> k;
        half = 38'd1 << (k - 6'd1);
        rem  = mag & ((38'd1 << k) - 38'd1);
        inc  = (rem > half) || ((rem == half) && q[0]);
        res  = (q + 38'(inc)) << k;
        if (lp < 6'd24)
        begin
            res = mag;
        end
        return res;
    endfunction

endpackage

// ===== sv/afq_table.sv =====
`include "assert_macros.svh"
module afq_table #(
    parameter int MAX_CHANNELS = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  afq_pkg::afq_in_t req,
    input  logic             per_channel_mode,
    input  logic             down_take,
    output logic             take,
    output afq_pkg::afq_s1_t s1
);
    import afq_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [63:0] mem [MAX_CHANNELS];
    logic        valid_reg;
    logic [31:0] sample_reg;
    logic        in_range_reg;
    logic [63:0] rd_reg;
    logic [12:0] wr_ext;
    logic [12:0] rd_ext;
    logic        wr_ok;
    logic        rd_ok;

    assign take   = !valid_reg || down_take;
    assign wr_ext = {5'd0, req.channel};
    assign rd_ext = per_channel_mode ? {5'd0, req.channel} : 13'd0;
    assign wr_ok  = wr_ext < 13'(MAX_CHANNELS);
    assign rd_ok  = rd_ext < 13'(MAX_CHANNELS);

    always_ff @(posedge clk)
    begin
        if (accept && (req.opcode == OP_WRITE) && wr_ok)
        begin
            mem[wr_ext[AW-1:0]] <= {req.recip_scale_bits, req.zero_offset};
        end
        if (take)
        begin
            rd_reg       <= mem[rd_ext[AW-1:0]];
            sample_reg   <= req.sample_bits;
            in_range_reg <= rd_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= accept && (req.opcode == OP_QUANT);
        end
    end

    assign s1 = '{valid: valid_reg, sample: sample_reg, recip: rd_reg[63:32],
                  offset: rd_reg[31:0], in_range: in_range_reg};

    // A table write never enters the arithmetic pipe.
    `AFQ_ASSERT_NXT(a_write_no_item, accept && (req.opcode == OP_WRITE), !valid_reg)

endmodule

// ===== sv/afq_mul.sv =====
`include "assert_macros.svh"
module afq_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  afq_pkg::afq_s1_t s1,
    input  logic             down_take,
    output logic             take,
    output afq_pkg::afq_s5_t s5
);
    import afq_pkg::*;

    typedef struct packed {
        logic              sign;
        logic              zero;
        logic              inf;
        logic              nan;
        logic signed [9:0] uexp;
        logic [23:0]       mant;
    } unpk_t;

    function automatic unpk_t unpack(input logic [31:0] x);
        unpk_t      u;
        logic [23:0] m;
        logic [5:0]  lp;
        logic [4:0]  nz;
        m      = {x[30:23] != 8'd0, x[22:0]};
        lp     = lead_pos(38'(m));
        nz     = 5'(6'd23 - lp);
        u.sign = x[31];
        u.zero = (x[30:0] == 31'd0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        u.mant = m << nz;
        u.uexp = $signed({2'b00, (x[30:23] == 8'd0) ? 8'd1 : x[30:23]}) - 10'sd127
                 - $signed({5'd0, nz});
        return u;
    endfunction

    logic take2, take3, take4, take5;

    // stage 2: unpack and normalize
    logic              v2_reg;
    logic              sign2_reg, nan2_reg, inf2_reg, zero2_reg;
    logic signed [9:0] e2_reg;
    logic [23:0]       ma2_reg, mb2_reg;
    logic              offneg2_reg;
    logic [31:0]       offmag2_reg;
    logic [5:0]        offlp2_reg;
    unpk_t             ua, ub;
    logic [31:0]       rb, ob, offmag;

    // stage 3: multiply
    logic              v3_reg;
    logic              sign3_reg, nan3_reg, inf3_reg, zero3_reg;
    logic signed [9:0] e3_reg;
    logic [47:0]       p3_reg;
    logic signed [33:0] off3_reg;
    logic [37:0]       offr;

    // stage 4: round to fp32
    logic              v4_reg;
    logic              sign4_reg, nan4_reg, huge4_reg, small4_reg;
    logic signed [9:0] e4_reg;
    logic [23:0]       m4_reg;
    logic signed [33:0] off4_reg;
    logic signed [9:0] e0, e1;
    logic [47:0]       mn;
    logic              inc4;
    logic [24:0]       m25;
    logic [23:0]       mr;

    // stage 5: round to integral
    logic              v5_reg;
    logic              sign5_reg, nan5_reg, huge5_reg;
    logic signed [34:0] r5_reg;
    logic signed [33:0] off5_reg;
    logic [56:0]       fx;
    logic [33:0]       rmag;
    logic [5:0]        sh;

    assign take5 = !v5_reg || down_take;
    assign take4 = !v4_reg || take5;
    assign take3 = !v3_reg || take4;
    assign take2 = !v2_reg || take3;
    assign take  = take2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (take2) v2_reg <= s1.valid;
            if (take3) v3_reg <= v2_reg;
            if (take4) v4_reg <= v3_reg;
            if (take5) v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        rb     = s1.in_range ? s1.recip : 32'd0;
        ob     = s1.in_range ? s1.offset : 32'd0;
        ua     = unpack(s1.sample);
        ub     = unpack(rb);
        offmag = ob[31] ? (32'd0 - ob) : ob;
    end

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            sign2_reg   <= ua.sign ^ ub.sign;
            nan2_reg    <= ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf);
            inf2_reg    <= ua.inf || ub.inf;
            zero2_reg   <= ua.zero || ub.zero;
            e2_reg      <= ua.uexp + ub.uexp;
            ma2_reg     <= ua.mant;
            mb2_reg     <= ub.mant;
            offneg2_reg <= ob[31];
            offmag2_reg <= offmag;
            offlp2_reg  <= lead_pos(38'(offmag));
        end
    end

    assign offr = rne24(38'(offmag2_reg), offlp2_reg);

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            sign3_reg <= sign2_reg;
            nan3_reg  <= nan2_reg;
            inf3_reg  <= inf2_reg;
            zero3_reg <= zero2_reg;
            e3_reg    <= e2_reg;
            p3_reg    <= 48'(ma2_reg) * 48'(mb2_reg);
            off3_reg  <= offneg2_reg ? (34'd0 - 34'(offr[32:0])) : 34'(offr[32:0]);
        end
    end

    always_comb
    begin
        e0   = e3_reg + $signed({9'd0, p3_reg[47]});
        mn   = p3_reg[47] ? p3_reg : {p3_reg[46:0], 1'b0};
        inc4 = mn[23] && ((|mn[22:0]) || mn[24]);
        m25  = {1'b0, mn[47:24]} + 25'(inc4);
        if (m25[24])
        begin
            mr = 24'h800000;
            e1 = e0 + 10'sd1;
        end
        else
        begin
            mr = m25[23:0];
            e1 = e0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take4)
        begin
            sign4_reg  <= sign3_reg;
            nan4_reg   <= nan3_reg;
            huge4_reg  <= !nan3_reg && (inf3_reg || (!zero3_reg && (e1 > 10'sd32)));
            small4_reg <= !inf3_reg && (zero3_reg || (e1 < -10'sd1));
            e4_reg     <= e1;
            m4_reg     <= mr;
            off4_reg   <= off3_reg;
        end
    end

    always_comb
    begin
        sh   = 6'(e4_reg + 10'sd1);
        fx   = 57'(m4_reg) << sh;
        rmag = 34'(fx[56:24]) + 34'(fx[23] && ((|fx[22:0]) || fx[24]));
        if (nan4_reg || huge4_reg || small4_reg)
        begin
            rmag = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take5)
        begin
            sign5_reg <= sign4_reg;
            nan5_reg  <= nan4_reg;
            huge5_reg <= huge4_reg;
            r5_reg    <= sign4_reg ? (35'd0 - 35'(rmag)) : 35'(rmag);
            off5_reg  <= off4_reg;
        end
    end

    assign s5 = '{valid: v5_reg, nan: nan5_reg, huge: huge5_reg, sign: sign5_reg,
                  rint: r5_reg, off: off5_reg};

    // The fp32 product leaves rounding with a normalized significand.
    `AFQ_ASSERT_NOW(a_norm_mant, v4_reg && !nan4_reg && !huge4_reg && !small4_reg,
                    m4_reg[23])

endmodule

// ===== sv/afq_sum.sv =====
`include "assert_macros.svh"
module afq_sum (
    input  logic              clk,
    input  logic              rst_n,
    input  afq_pkg::afq_s5_t  s5,
    input  afq_pkg::afq_cfg_t cfg,
    input  logic              rsp_stall,
    output logic              take,
    output logic              rsp_valid,
    output afq_pkg::afq_out_t rsp_data
);
    import afq_pkg::*;

    localparam logic signed [33:0] SAT_HI = 34'sd2147483648;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483649;

    logic take6, take7, take8, take9;

    logic               v6_reg, nan6_reg, huge6_reg, sign6_reg;
    logic signed [37:0] s6_reg;

    logic               v7_reg, nan7_reg, huge7_reg, sign7_reg, neg7_reg;
    logic [37:0]        mag7_reg;
    logic [5:0]         lp7_reg;
    logic [37:0]        mag;

    logic               v8_reg, nan8_reg;
    logic signed [33:0] q8_reg;
    logic [37:0]        rr;
    logic signed [37:0] sv;
    logic signed [33:0] qn;

    logic               v9_reg, nan9_reg;
    logic signed [31:0] q9_reg;
    logic signed [33:0] lo, hi, c1, c2;

    assign take9 = !v9_reg || !rsp_stall;
    assign take8 = !v8_reg || take9;
    assign take7 = !v7_reg || take8;
    assign take6 = !v6_reg || take7;
    assign take  = take6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            if (take6) v6_reg <= s5.valid;
            if (take7) v7_reg <= v6_reg;
            if (take8) v8_reg <= v7_reg;
            if (take9) v9_reg <= v8_reg;
        end
    end

    // exact integer sum of the converted zero point and the rounded product
    always_ff @(posedge clk)
    begin
        if (take6)
        begin
            nan6_reg  <= s5.nan;
            huge6_reg <= s5.huge;
            sign6_reg <= s5.sign;
            s6_reg    <= 38'(s5.off) + 38'(s5.rint);
        end
    end

    assign mag = s6_reg[37] ? (38'd0 - s6_reg) : s6_reg;

    always_ff @(posedge clk)
    begin
        if (take7)
        begin
            nan7_reg  <= nan6_reg;
            huge7_reg <= huge6_reg;
            sign7_reg <= sign6_reg;
            neg7_reg  <= s6_reg[37];
            mag7_reg  <= mag;
            lp7_reg   <= lead_pos(mag);
        end
    end

    // round sum to fp32, then saturate to one past the int32 range
    always_comb
    begin
        rr = rne24(mag7_reg, lp7_reg);
        sv = neg7_reg ? (38'sd0 - $signed(rr)) : $signed(rr);
        if (huge7_reg)
        begin
            qn = sign7_reg ? SAT_LO : SAT_HI;
        end
        else if (sv >= 38'sd2147483648)
        begin
            qn = SAT_HI;
        end
        else if (sv < -38'sd2147483648)
        begin
            qn = SAT_LO;
        end
        else
        begin
            qn = 34'(sv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take8)
        begin
            nan8_reg <= nan7_reg;
            q8_reg   <= qn;
        end
    end

    always_comb
    begin
        lo = 34'(cfg.clamp_low);
        hi = 34'(cfg.clamp_high);
        c1 = (q8_reg < lo) ? lo : q8_reg;
        c2 = (c1 > hi) ? hi : c1;
        if (nan8_reg)
        begin
            c2 = lo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take9)
        begin
            nan9_reg <= nan8_reg;
            q9_reg   <= c2[31:0];
        end
    end

    assign rsp_valid = v9_reg;
    assign rsp_data  = '{qvalue: q9_reg, nan_input: nan9_reg};

    `AFQ_ASSERT_NOW(a_nan_low, v9_reg && nan9_reg, q9_reg == cfg.clamp_low)
    `AFQ_ASSERT_NOW(a_in_bounds,
                    v9_reg && !nan9_reg && (cfg.clamp_low <= cfg.clamp_high),
                    (q9_reg >= cfg.clamp_low) && (q9_reg <= cfg.clamp_high))

endmodule

// ===== sv/affine_float_quantizer.sv =====
// Throughput: one transaction per cycle while rsp_stall is low.
// Eight arithmetic stages plus the table read register.
// A table write takes effect for the very next transaction and produces no response.
// Reset clears all pipeline valid bits and loads clamp_low 0, clamp_high 255, mode 0.
// Table contents are not cleared by reset and hold garbage until written.
module affine_float_quantizer #(
    parameter int MAX_CHANNELS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  afq_pkg::afq_in_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output afq_pkg::afq_out_t rsp_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import afq_pkg::*;

    afq_cfg_t cfg_reg;
    afq_s1_t  s1;
    afq_s5_t  s5;
    logic     take1, take2, take6;
    logic     accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clamp_low        <= 32'sd0;
            cfg_reg.clamp_high       <= 32'sd255;
            cfg_reg.per_channel_mode <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLAMP_LOW:  cfg_reg.clamp_low        <= cfg_data;
                CFG_CLAMP_HIGH: cfg_reg.clamp_high       <= cfg_data;
                CFG_CHAN_MODE:  cfg_reg.per_channel_mode <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign req_stall = !take1;
    assign accept    = req_valid && take1;

    afq_table #(.MAX_CHANNELS(MAX_CHANNELS)) u_table (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .req              (req_data),
        .per_channel_mode (cfg_reg.per_channel_mode),
        .down_take        (take2),
        .take             (take1),
        .s1               (s1)
    );

    afq_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1        (s1),
        .down_take (take6),
        .take      (take2),
        .s5        (s5)
    );

    afq_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s5        (s5),
        .cfg       (cfg_reg),
        .rsp_stall (rsp_stall),
        .take      (take6),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import afq_pkg::*;

    typedef struct {
        afq_in_t  req;
        bit       known;
        afq_out_t want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    afq_in_t           req_data;
    logic              rsp_valid;
    logic              rsp_stall;
    afq_out_t          rsp_data;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;

    logic signed [31:0] cur_low;
    logic signed [31:0] cur_high;
    logic               cur_mode;
    logic [31:0]        recip_tbl [256];
    logic signed [31:0] zp_tbl [256];
    bit                 written [256];

    afq_out_t  pending_q [$];
    stim_row_t rows [$];
    int        fail_count;
    int        rx_count;
    bit        tx_calm;

    affine_float_quantizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("affine_float_quantizer test failed");
        $finish;
    end

    // Round an integer to 24 significant bits, ties to even (int to fp32).
    function automatic longint round24(longint v);
        longint mag;
        longint q;
        longint rem;
        longint half;
        int     lp;
        int     k;
        mag = (v < 0) ? -v : v;
        if (mag < (64'sd1 <<< 24))
            return v;
        lp = 0;
        for (int i = 0; i < 63; i++)
        begin
            if (mag[i])
                lp = i;
        end
        k    = lp - 23;
        q    = mag >>> k;
        rem  = mag & ((64'sd1 <<< k) - 1);
        half = 64'sd1 <<< (k - 1);
        if (rem > half || (rem == half && q[0]))
            q++;
        q = q <<< k;
        return (v < 0) ? -q : q;
    endfunction

    function automatic afq_out_t quantize_sample(logic [31:0] smp, logic [31:0] rcp,
                                                 logic signed [31:0] zp);
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [22:0] fa;
        logic [22:0] fb;
        logic        neg;
        bit          inf_p;
        longint      ma;
        longint      mb;
        longint      m;
        longint      q;
        longint      r;
        longint      rem;
        longint      half;
        longint      val;
        int          xa;
        int          xb;
        int          x;
        int          y;
        int          lp;
        int          k;
        afq_out_t    res;
        ea  = smp[30:23];
        fa  = smp[22:0];
        eb  = rcp[30:23];
        fb  = rcp[22:0];
        neg = smp[31] ^ rcp[31];
        res.nan_input = 1'b0;
        if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0) ||
            (ea == 8'hFF && eb == 0 && fb == 0) || (eb == 8'hFF && ea == 0 && fa == 0))
        begin
            res.qvalue    = cur_low;
            res.nan_input = 1'b1;
            return res;
        end
        inf_p = (ea == 8'hFF) || (eb == 8'hFF);
        r = 0;
        if (!inf_p)
        begin
            ma = (ea == 0) ? longint'(fa) : longint'({1'b1, fa});
            mb = (eb == 0) ? longint'(fb) : longint'({1'b1, fb});
            xa = (ea == 0) ? 1 : int'(ea);
            xb = (eb == 0) ? 1 : int'(eb);
            m  = ma * mb;
            x  = xa + xb - 300;
            if (m != 0)
            begin
                lp = 0;
                for (int i = 0; i < 63; i++)
                begin
                    if (m[i])
                        lp = i;
                end
                // below one half the product rounds to zero whatever fp32 does
                if (lp + x >= -1)
                begin
                    k = lp - 23;
                    q = m;
                    y = x;
                    if (k > 0)
                    begin
                        q    = m >>> k;
                        rem  = m & ((64'sd1 <<< k) - 1);
                        half = 64'sd1 <<< (k - 1);
                        if (rem > half || (rem == half && q[0]))
                            q++;
                        y = x + k;
                    end
                    if (q == (64'sd1 <<< 24))
                    begin
                        q = q >>> 1;
                        y++;
                    end
                    if (y > 30)
                        inf_p = 1;
                    else if (y >= 0)
                        r = q <<< y;
                    else
                    begin
                        k    = -y;
                        r    = q >>> k;
                        rem  = q & ((64'sd1 <<< k) - 1);
                        half = 64'sd1 <<< (k - 1);
                        if (rem > half || (rem == half && r[0]))
                            r++;
                    end
                end
            end
        end
        if (inf_p)
            val = neg ? -64'sd2147483649 : 64'sd2147483648;
        else
        begin
            val = round24(round24(longint'(zp)) + (neg ? -r : r));
            if (val >= 64'sd2147483648)
                val = 64'sd2147483648;
        end
        if (val < longint'(cur_low))
            val = longint'(cur_low);
        if (val > longint'(cur_high))
            val = longint'(cur_high);
        res.qvalue = val[31:0];
        return res;
    endfunction

    task automatic add_row(logic op, logic [7:0] ch, logic [31:0] smp, logic [31:0] rcp,
                           logic [31:0] zp, int known, logic [31:0] qv, int nf);
        stim_row_t row;
        row.req.opcode           = op;
        row.req.channel          = ch;
        row.req.sample_bits      = smp;
        row.req.recip_scale_bits = rcp;
        row.req.zero_offset      = zp;
        row.known                = (known != 0);
        row.want.qvalue          = qv;
        row.want.nan_input       = (nf != 0);
        rows.push_back(row);
    endtask

    // Offer one transaction after a gap; record its effect once accepted.
    task automatic send_item(afq_in_t item, bit known, afq_out_t want);
        int gap;
        bit acc;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
        begin
            @(negedge clk);
            acc = !req_stall;
            @(posedge clk);
        end
        while (!acc);
        if (item.opcode == OP_WRITE)
        begin
            recip_tbl[item.channel] = item.recip_scale_bits;
            zp_tbl[item.channel]    = item.zero_offset;
            written[item.channel]   = 1'b1;
        end
        else if (known)
            pending_q.push_back(want);
        else
        begin
            if (cur_mode)
                pending_q.push_back(quantize_sample(item.sample_bits,
                                    recip_tbl[item.channel], zp_tbl[item.channel]));
            else
                pending_q.push_back(quantize_sample(item.sample_bits, recip_tbl[0], zp_tbl[0]));
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_cfg(logic signed [31:0] lo, logic signed [31:0] hi, logic md);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLAMP_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_CLAMP_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_CHAN_MODE;
        cfg_data  <= {31'd0, md};
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_low  = lo;
        cur_high = hi;
        cur_mode = md;
    endtask

    function automatic logic [31:0] rand_sample();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7F800000;
                    1: v = 32'hFF800000;
                    2: v = 32'h7FC00000 | $urandom_range(0, 1023);
                    3: v = {$urandom_range(0, 1) == 1, 31'd0};
                    4: v = {$urandom_range(0, 1) == 1, 8'd126, 23'd0};
                    default: v = {$urandom_range(0, 1) == 1, 8'($urandom_range(127, 150)), 23'd0};
                endcase
            end
            default: v = {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 158)),
                          23'($urandom)};
        endcase
        return v;
    endfunction

    function automatic afq_in_t rand_item(bit allow_write);
        afq_in_t item;
        int      tries;
        item.sample_bits      = rand_sample();
        item.recip_scale_bits = ($urandom_range(0, 4) == 0) ? $urandom :
            {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 135)), 23'($urandom)};
        item.zero_offset      = ($urandom_range(0, 3) == 0) ? $urandom :
            $urandom_range(0, 400) - 200;
        item.channel          = 8'($urandom);
        item.opcode           = (allow_write && $urandom_range(0, 3) == 0) ? OP_WRITE : OP_QUANT;
        // never read an entry that was never written
        if (item.opcode == OP_QUANT && cur_mode)
        begin
            tries = 0;
            while (!written[item.channel] && tries < 1000)
            begin
                item.channel = 8'($urandom);
                tries++;
            end
            if (!written[item.channel])
                item.opcode = OP_WRITE;
        end
        return item;
    endfunction

    // Result side: random stalls, one long hold to back up the pipeline.
    initial
    begin
        int n;
        bit acc;
        bit calm;
        afq_out_t got;
        afq_out_t want;
        calm = 0;
        @(posedge rst_n);
        forever
        begin
            if (rx_count % 100 == 0)
                calm = $urandom_range(0, 3) == 0;
            n = calm ? 0 : $urandom_range(0, 16);
            if (rx_count == 300)
                n = 400;
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do
            begin
                @(negedge clk);
                acc = rsp_valid && !rsp_stall;
                got = rsp_data;
                @(posedge clk);
            end
            while (!acc);
            rx_count++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result qvalue=%0d nan_input=%0b", got.qvalue, got.nan_input);
                fail_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.qvalue !== want.qvalue)
                begin
                    $error("qvalue: expected %0d, actual %0d", want.qvalue, got.qvalue);
                    fail_count++;
                end
                if (got.nan_input !== want.nan_input)
                begin
                    $error("nan_input: expected %0b, actual %0b", want.nan_input, got.nan_input);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        afq_out_t none;
        afq_in_t  item;
        int       lows  [5];
        int       highs [5];
        int       modes [5];
        int       counts[5];
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        rsp_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_CLAMP_LOW;
        cfg_data   = '0;
        fail_count = 0;
        rx_count   = 0;
        tx_calm    = 0;
        cur_low    = 0;
        cur_high   = 255;
        cur_mode   = 0;
        none       = '0;
        lows   = '{-2147483648, -128, 200, -1000, 2147483647};
        highs  = '{2147483647, 127, 100, 1000, -2147483648};
        modes  = '{1, 1, 0, 0, 1};
        counts = '{260, 220, 200, 230, 120};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset clamp range [0, 255], per-tensor mode
        add_row(OP_WRITE, 8'd0, 32'h0, 32'h3F800000, 32'd0, 0, 0, 0);
        add_row(OP_QUANT, 8'd7, 32'h40200000, 0, 0, 1, 32'd2, 0);
        add_row(OP_QUANT, 8'd0, 32'h40600000, 0, 0, 1, 32'd4, 0);
        add_row(OP_QUANT, 8'd0, 32'h3F000000, 0, 0, 1, 32'd0, 0);
        add_row(OP_QUANT, 8'd0, 32'h3FC00000, 0, 0, 1, 32'd2, 0);
        add_row(OP_QUANT, 8'd0, 32'hBF800000, 0, 0, 1, 32'd0, 0);
        add_row(OP_QUANT, 8'd0, 32'h7F800000, 0, 0, 1, 32'd255, 0);
        add_row(OP_QUANT, 8'd0, 32'hFF800000, 0, 0, 1, 32'd0, 0);
        add_row(OP_QUANT, 8'd0, 32'h7FC00000, 0, 0, 1, 32'd0, 1);
        add_row(OP_QUANT, 8'd0, 32'hFFFFFFFF, 0, 0, 1, 32'd0, 1);
        add_row(OP_QUANT, 8'd0, 32'h43960000, 0, 0, 1, 32'd255, 0);
        add_row(OP_QUANT, 8'd0, 32'h00000000, 0, 0, 1, 32'd0, 0);
        add_row(OP_QUANT, 8'd0, 32'h80000000, 0, 0, 1, 32'd0, 0);
        add_row(OP_QUANT, 8'd0, 32'h7F7FFFFF, 0, 0, 1, 32'd255, 0);
        add_row(OP_QUANT, 8'd0, 32'h00000001, 0, 0, 1, 32'd0, 0);
        // zero reciprocal: zero times infinity is NaN
        add_row(OP_WRITE, 8'd0, 32'h0, 32'h00000000, 32'd10, 0, 0, 0);
        add_row(OP_QUANT, 8'd0, 32'h7F800000, 0, 0, 1, 32'd0, 1);
        add_row(OP_QUANT, 8'd0, 32'h40A00000, 0, 0, 1, 32'd10, 0);
        add_row(OP_WRITE, 8'd0, 32'h0, 32'h7F800000, 32'h80000000, 0, 0, 0);
        add_row(OP_QUANT, 8'd0, 32'h3F800000, 0, 0, 1, 32'd255, 0);
        add_row(OP_QUANT, 8'd0, 32'h00000000, 0, 0, 1, 32'd0, 1);
        add_row(OP_WRITE, 8'd255, 32'hFFFFFFFF, 32'h3F800000, 32'h7FFFFFFF, 0, 0, 0);
        add_row(OP_QUANT, 8'd255, 32'hBF800000, 0, 0, 1, 32'd0, 0);
        add_row(OP_QUANT, 8'd128, 32'h4B000001, 0, 0, 0, 0, 0);
        add_row(OP_WRITE, 8'd0, 32'h0, 32'h3F800000, 32'd0, 0, 0, 0);
        foreach (rows[i])
            send_item(rows[i].req, rows[i].known, rows[i].want);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_cfg(lows[p], highs[p], modes[p][0]);
            for (int i = 0; i < counts[p]; i++)
            begin
                if (i % 50 == 0)
                    tx_calm = $urandom_range(0, 3) == 0;
                item = rand_item(1);
                send_item(item, 0, none);
            end
            // hold until the pipeline is empty
            drain();
        end

        if (fail_count == 0 && pending_q.size() == 0)
            $display("affine_float_quantizer test passed");
        else
            $display("affine_float_quantizer test failed");
        $finish;
    end
endmodule
